/* rtl/core/mpam_pkg.sv */
// Shared types and constants for the multi-pattern automaton matcher.
// Used by mpam_ctrl, mpam_dpath and the top level; no dependencies.
`timescale 1ns / 1ps
package mpam_pkg;

   localparam int ALPHABET_SIZE   = 26;
   localparam int MAX_NODES       = 1024;
   localparam int MAX_PATTERN_LEN = 64;
   localparam int MAX_RESULTS     = 64;
   localparam int POS_W           = 32;
   localparam int NODE_W          = $clog2(MAX_NODES);
   localparam int CNT_W           = NODE_W + 1;
   localparam int SYM_W           = 5;
   localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);
   localparam int GT_AW           = NODE_W + SYM_W;
   localparam int K_W             = $clog2(MAX_RESULTS);

   // input operation codes
   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_PSYM   = 3'd1,
      OP_PEND   = 3'd2,
      OP_BUILD  = 3'd3,
      OP_TSTART = 3'd4,
      OP_TSYM   = 3'd5
   } op_code_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_MATCH = 3'd1,
      KIND_FULL  = 3'd2,
      KIND_BAD   = 3'd3,
      KIND_PHASE = 3'd4
   } kind_type;

   // datapath micro-operations
   typedef enum logic [4:0] {
      DP_NOP, DP_TAKE, DP_CLR,
      DP_PS_RD, DP_PS_ADV, DP_PS_NEW, DP_PE,
      DP_TS_START, DP_TX_RD, DP_TX_STEP, DP_V_LOAD, DP_W_RD, DP_W_FO, DP_V_NEXT,
      DP_B_INIT, DP_B_QRD, DP_B_VLD, DP_B_ULD, DP_B_OL,
      DP_B_G1, DP_B_G2, DP_B_G3, DP_B_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
      kind_type  kind;
      logic      last;
      logic      match;
   } dp_cmd_type;

   typedef struct packed {
      logic built;
      logic sym_bad;
      logic len_full;
      logic cnt_full;
      logic nx_zero;
      logic v_zero;
      logic nv_zero;
      logic k_last;
      logic c_last;
      logic q_empty;
      logic clr_last;
   } dp_stat_type;

endpackage

/* rtl/core/mpam_dpath.sv */
// Datapath of the matcher: transition, link, depth and queue memories,
// scan and build registers, and the result word register. Uses mpam_pkg.
`timescale 1ns / 1ps
module mpam_dpath import mpam_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  logic [SYM_W-1:0]   req_symbol,
   output dp_stat_type        stat,
   output logic [2:0]         rsp_kind,
   output logic [31:0]        rsp_match_start,
   output logic [31:0]        rsp_match_end,
   output logic               rsp_last
);

   logic [NODE_W-1:0] goto_mem  [2**GT_AW];
   logic [NODE_W-1:0] fail_mem  [MAX_NODES];
   logic [NODE_W-1:0] out_mem   [MAX_NODES];
   logic [LEN_W-1:0]  depth_mem [MAX_NODES];
   logic [NODE_W-1:0] queue_mem [MAX_NODES];

   logic              gt_we, gt_re, fl_we, fl_re, ol_we, ol_re, dp_we, dp_re, q_we, q_re;
   logic [GT_AW-1:0]  gt_wa, gt_ra;
   logic [NODE_W-1:0] gt_wd, fl_wa, fl_wd, fl_ra, ol_wa, ol_wd, ol_ra;
   logic [NODE_W-1:0] dp_wa, dp_ra, q_wa, q_wd, q_ra;
   logic [LEN_W-1:0]  dp_wd;

   logic [NODE_W-1:0] gt_rd_ff, fl_rd_ff, ol_rd_ff, q_rd_ff;
   logic [LEN_W-1:0]  dp_rd_ff;

   logic [CNT_W-1:0]  cnt_ff, head_ff, tail_ff;
   logic [NODE_W-1:0] ins_ff, scan_ff, v_ff, u_ff, ov_ff, nx_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [POS_W-1:0]  pos_ff, pcur_ff;
   logic              built_ff;
   logic [GT_AW-1:0]  clr_ff;
   logic [SYM_W-1:0]  c_ff, sym_ff;
   logic [K_W-1:0]    k_ff;
   kind_type          kind_ff;
   logic [31:0]       start_ff, end_ff;
   logic              last_ff;

   // status back to the controller
   assign stat.built    = built_ff;
   assign stat.sym_bad  = (sym_ff >= SYM_W'(ALPHABET_SIZE));
   assign stat.len_full = (len_ff >= LEN_W'(MAX_PATTERN_LEN));
   assign stat.cnt_full = (cnt_ff >= CNT_W'(MAX_NODES));
   assign stat.nx_zero  = (gt_rd_ff == '0);
   assign stat.v_zero   = (v_ff == '0);
   assign stat.nv_zero  = (ol_rd_ff == '0);
   assign stat.k_last   = (k_ff == K_W'(MAX_RESULTS - 1));
   assign stat.c_last   = (c_ff == SYM_W'(ALPHABET_SIZE - 1));
   assign stat.q_empty  = (head_ff == tail_ff);
   assign stat.clr_last = (clr_ff == '1);

   assign rsp_kind        = kind_ff;
   assign rsp_match_start = start_ff;
   assign rsp_match_end   = end_ff;
   assign rsp_last        = last_ff;

   // steer memory ports for the current micro-operation
   always_comb begin
      gt_we = 1'b0; gt_wa = '0; gt_wd = '0; gt_re = 1'b0; gt_ra = '0;
      fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_re = 1'b0; fl_ra = '0;
      ol_we = 1'b0; ol_wa = '0; ol_wd = '0; ol_re = 1'b0; ol_ra = '0;
      dp_we = 1'b0; dp_wa = '0; dp_wd = '0; dp_re = 1'b0; dp_ra = '0;
      q_we  = 1'b0; q_wa  = '0; q_wd  = '0; q_re  = 1'b0; q_ra  = '0;
      case (cmd.op)
         DP_CLR: begin
            gt_we = 1'b1; gt_wa = clr_ff;
            fl_we = 1'b1; fl_wa = clr_ff[GT_AW-1:SYM_W];
            ol_we = 1'b1; ol_wa = clr_ff[GT_AW-1:SYM_W];
         end
         DP_PS_RD: begin
            gt_re = 1'b1; gt_ra = {ins_ff, sym_ff};
         end
         DP_PS_NEW: begin
            gt_we = 1'b1; gt_wa = {ins_ff, sym_ff}; gt_wd = cnt_ff[NODE_W-1:0];
            dp_we = 1'b1; dp_wa = cnt_ff[NODE_W-1:0]; dp_wd = len_ff + LEN_W'(1);
         end
         DP_PE: begin
            ol_we = (len_ff != '0); ol_wa = ins_ff; ol_wd = ins_ff;
         end
         DP_TX_RD: begin
            gt_re = 1'b1; gt_ra = {scan_ff, sym_ff};
         end
         DP_TX_STEP: begin
            ol_re = 1'b1; ol_ra = gt_rd_ff;
         end
         DP_W_RD: begin
            dp_re = 1'b1; dp_ra = v_ff;
            fl_re = 1'b1; fl_ra = v_ff;
         end
         DP_W_FO: begin
            ol_re = 1'b1; ol_ra = fl_rd_ff;
         end
         DP_B_INIT: begin
            q_we = 1'b1;
         end
         DP_B_QRD: begin
            q_re = 1'b1; q_ra = head_ff[NODE_W-1:0];
         end
         DP_B_VLD: begin
            fl_re = 1'b1; fl_ra = q_rd_ff;
            ol_re = 1'b1; ol_ra = q_rd_ff;
         end
         DP_B_ULD: begin
            ol_re = 1'b1; ol_ra = fl_rd_ff;
         end
         DP_B_OL: begin
            ol_we = (ov_ff == '0); ol_wa = v_ff; ol_wd = ol_rd_ff;
         end
         DP_B_G1: begin
            gt_re = 1'b1; gt_ra = {v_ff, c_ff};
         end
         DP_B_G2: begin
            gt_re = 1'b1; gt_ra = {u_ff, c_ff};
         end
         DP_B_G3: begin
            if (nx_ff == '0) begin
               gt_we = 1'b1; gt_wa = {v_ff, c_ff}; gt_wd = gt_rd_ff;
            end else begin
               fl_we = 1'b1; fl_wa = nx_ff;
               fl_wd = (v_ff != '0) ? gt_rd_ff : '0;
               q_we  = (tail_ff < CNT_W'(MAX_NODES));
               q_wa  = tail_ff[NODE_W-1:0]; q_wd = nx_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (gt_we) goto_mem[gt_wa] <= gt_wd;
      if (gt_re) gt_rd_ff <= goto_mem[gt_ra];
      if (fl_we) fail_mem[fl_wa] <= fl_wd;
      if (fl_re) fl_rd_ff <= fail_mem[fl_ra];
      if (ol_we) out_mem[ol_wa] <= ol_wd;
      if (ol_re) ol_rd_ff <= out_mem[ol_ra];
      if (dp_we) depth_mem[dp_wa] <= dp_wd;
      if (dp_re) dp_rd_ff <= depth_mem[dp_ra];
      if (q_we)  queue_mem[q_wa] <= q_wd;
      if (q_re)  q_rd_ff <= queue_mem[q_ra];
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_TAKE:    sym_ff <= req_symbol;
         DP_TX_STEP: pcur_ff <= pos_ff;
         DP_V_LOAD:  v_ff <= ol_rd_ff;
         DP_V_NEXT:  v_ff <= ol_rd_ff;
         DP_B_VLD:   v_ff <= q_rd_ff;
         DP_B_ULD: begin
            u_ff  <= fl_rd_ff;
            ov_ff <= ol_rd_ff;
         end
         DP_B_OL:    c_ff <= '0;
         DP_B_G2:    nx_ff <= gt_rd_ff;
         DP_B_G3:    c_ff <= c_ff + SYM_W'(1);
         default: begin
         end
      endcase
      // load the result word
      if (cmd.emit) begin
         kind_ff <= cmd.kind;
         last_ff <= cmd.last;
         if (cmd.match) begin
            start_ff <= 32'(pcur_ff + POS_W'(1) - POS_W'(dp_rd_ff));
            end_ff   <= 32'(pcur_ff);
         end else begin
            start_ff <= '0;
            end_ff   <= '0;
         end
      end
   end

   // control-bearing state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= CNT_W'(1);
         ins_ff   <= '0;
         len_ff   <= '0;
         scan_ff  <= '0;
         pos_ff   <= '0;
         built_ff <= 1'b0;
         clr_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         k_ff     <= '0;
      end else begin
         case (cmd.op)
            DP_CLR: begin
               cnt_ff   <= CNT_W'(1);
               ins_ff   <= '0;
               len_ff   <= '0;
               scan_ff  <= '0;
               pos_ff   <= '0;
               built_ff <= 1'b0;
               clr_ff   <= clr_ff + GT_AW'(1);
            end
            DP_PS_ADV: begin
               ins_ff <= gt_rd_ff;
               len_ff <= len_ff + LEN_W'(1);
            end
            DP_PS_NEW: begin
               ins_ff <= cnt_ff[NODE_W-1:0];
               cnt_ff <= cnt_ff + CNT_W'(1);
               len_ff <= len_ff + LEN_W'(1);
            end
            DP_PE: begin
               ins_ff <= '0;
               len_ff <= '0;
            end
            DP_TS_START: begin
               scan_ff <= '0;
               pos_ff  <= '0;
            end
            DP_TX_STEP: begin
               scan_ff <= gt_rd_ff;
               pos_ff  <= pos_ff + POS_W'(1);
            end
            DP_V_LOAD: k_ff <= '0;
            DP_V_NEXT: k_ff <= k_ff + K_W'(1);
            DP_B_INIT: begin
               head_ff <= '0;
               tail_ff <= CNT_W'(1);
            end
            DP_B_QRD: head_ff <= head_ff + CNT_W'(1);
            DP_B_G3: begin
               if (nx_ff != '0 && tail_ff < CNT_W'(MAX_NODES))
                  tail_ff <= tail_ff + CNT_W'(1);
            end
            DP_B_FIN: begin
               built_ff <= 1'b1;
               ins_ff   <= '0;
               len_ff   <= '0;
               scan_ff  <= '0;
               pos_ff   <= '0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

/* rtl/core/mpam_ctrl.sv */
// Controller of the matcher: sequences clear, insert, link build and scan
// through datapath micro-operations and owns the handshakes. Uses mpam_pkg.
`timescale 1ns / 1ps
module mpam_ctrl import mpam_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DISP, ST_PS_CHK, ST_TX_STEP, ST_TX_FIRST, ST_CHAIN,
      ST_W_FO, ST_W_NX, ST_B_POP, ST_B_V, ST_B_U, ST_B_OL, ST_B_G1, ST_B_G2,
      ST_B_G3, ST_RESP
   } state_type;

   state_type   state_ff, state_in;
   op_code_type op_ff, op_in;
   kind_type    kind_ff, kind_in;
   logic        from_op_ff, from_op_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        slot_free, chain_last;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign chain_last = stat.nv_zero || stat.k_last;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;

   // next state and micro-operation
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      kind_in    = kind_ff;
      from_op_in = from_op_ff;
      cmd        = '{op: DP_NOP, emit: 1'b0, kind: KIND_NONE, last: 1'b1, match: 1'b0};
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = DP_CLR;
            if (stat.clr_last) begin
               kind_in  = KIND_NONE;
               state_in = from_op_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_TAKE;
               op_in    = op_code_type'(req_operation);
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            state_in = ST_RESP;
            kind_in  = KIND_NONE;
            case (op_ff)
               OP_CLEAR: begin
                  from_op_in = 1'b1;
                  state_in   = ST_CLEAR;
               end
               OP_PSYM: begin
                  if (stat.built) kind_in = KIND_PHASE;
                  else if (stat.sym_bad || stat.len_full) kind_in = KIND_BAD;
                  else begin
                     cmd.op   = DP_PS_RD;
                     state_in = ST_PS_CHK;
                  end
               end
               OP_PEND: begin
                  if (stat.built) kind_in = KIND_PHASE;
                  else cmd.op = DP_PE;
               end
               OP_BUILD: begin
                  if (stat.built) kind_in = KIND_PHASE;
                  else begin
                     cmd.op   = DP_B_INIT;
                     state_in = ST_B_POP;
                  end
               end
               OP_TSTART: begin
                  if (!stat.built) kind_in = KIND_PHASE;
                  else cmd.op = DP_TS_START;
               end
               OP_TSYM: begin
                  if (!stat.built) kind_in = KIND_PHASE;
                  else if (stat.sym_bad) kind_in = KIND_BAD;
                  else begin
                     cmd.op   = DP_TX_RD;
                     state_in = ST_TX_STEP;
                  end
               end
               default: kind_in = KIND_PHASE;
            endcase
         end
         // insert: follow an existing edge or add a node
         ST_PS_CHK: begin
            state_in = ST_RESP;
            kind_in  = KIND_NONE;
            if (!stat.nx_zero) cmd.op = DP_PS_ADV;
            else if (stat.cnt_full) kind_in = KIND_FULL;
            else cmd.op = DP_PS_NEW;
         end
         // scan: step the automaton, then walk the output chain
         ST_TX_STEP: begin
            cmd.op   = DP_TX_STEP;
            state_in = ST_TX_FIRST;
         end
         ST_TX_FIRST: begin
            cmd.op   = DP_V_LOAD;
            state_in = ST_CHAIN;
         end
         ST_CHAIN: begin
            if (stat.v_zero) begin
               kind_in  = KIND_NONE;
               state_in = ST_RESP;
            end else begin
               cmd.op   = DP_W_RD;
               state_in = ST_W_FO;
            end
         end
         ST_W_FO: begin
            cmd.op   = DP_W_FO;
            state_in = ST_W_NX;
         end
         ST_W_NX: begin
            if (slot_free) begin
               cmd.op    = DP_V_NEXT;
               cmd.emit  = 1'b1;
               cmd.kind  = KIND_MATCH;
               cmd.match = 1'b1;
               cmd.last  = chain_last;
               state_in  = chain_last ? ST_IDLE : ST_CHAIN;
            end
         end
         // build: breadth-first pass over the trie
         ST_B_POP: begin
            if (stat.q_empty) begin
               cmd.op   = DP_B_FIN;
               kind_in  = KIND_NONE;
               state_in = ST_RESP;
            end else begin
               cmd.op   = DP_B_QRD;
               state_in = ST_B_V;
            end
         end
         ST_B_V: begin
            cmd.op   = DP_B_VLD;
            state_in = ST_B_U;
         end
         ST_B_U: begin
            cmd.op   = DP_B_ULD;
            state_in = ST_B_OL;
         end
         ST_B_OL: begin
            cmd.op   = DP_B_OL;
            state_in = ST_B_G1;
         end
         ST_B_G1: begin
            cmd.op   = DP_B_G1;
            state_in = ST_B_G2;
         end
         ST_B_G2: begin
            cmd.op   = DP_B_G2;
            state_in = ST_B_G3;
         end
         ST_B_G3: begin
            cmd.op   = DP_B_G3;
            state_in = stat.c_last ? ST_B_POP : ST_B_G1;
         end
         // single-word answer
         ST_RESP: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = kind_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         op_ff        <= OP_CLEAR;
         kind_ff      <= KIND_NONE;
         from_op_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         kind_ff      <= kind_in;
         from_op_ff   <= (state_ff == ST_CLEAR && stat.clr_last) ? 1'b0 : from_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/core/multi_pattern_automaton_matcher.sv */
// Multi-pattern (Aho-Corasick) matcher: request channel in, result words out.
//
// Usage: send pattern symbols (operation 1), close each pattern (2), then
// build links (3). Start text (4) and send text symbols (5); every pattern
// that ends at a text position comes back as one match word, longest first,
// with rsp_last set on the final word of that symbol. All other requests give
// exactly one word with rsp_last set. Clear (0) empties the automaton.
// Each match word of a text symbol comes from a depth and failure read, an
// output-link read, and then the loading of the word. One request is worked
// on at a time. Reset and clear run a clearing pass over the 32768 entries of
// the transition memory (one entry per cycle), during which req_ready stays
// low. rsp_valid holds a word in an output register until rsp_ready; a stalled
// receiver stops the match walk but does not lose or repeat any word.
`timescale 1ns / 1ps
module multi_pattern_automaton_matcher import mpam_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [4:0]  req_symbol,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_match_start,
   output logic [31:0] rsp_match_end,
   output logic        rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   mpam_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   mpam_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_symbol      (req_symbol),
      .stat            (stat),
      .rsp_kind        (rsp_kind),
      .rsp_match_start (rsp_match_start),
      .rsp_match_end   (rsp_match_end),
      .rsp_last        (rsp_last)
   );

endmodule
